[rtl/core/tgl_pkg.sv]
// ---------------------------------------------------------------------------
// tgl_pkg: shared types and constants for the text glyph layout block
// Register map, character codes, highlight colors and the glyph bundle
// that travels from the front stage to the back stage.
// ---------------------------------------------------------------------------
package tgl_pkg;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
	localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd2;
	localparam logic [2:0] REG_NARROW_SPACE = 3'd3;
	localparam logic [2:0] REG_BASE_COLOR   = 3'd4;

	localparam int PADDR_W = 5;

	// reset values of the registers
	localparam logic [15:0] ORIGIN_X_RST     = 16'd0;
	localparam logic [15:0] ORIGIN_Y_RST     = 16'd0;
	localparam logic [5:0]  GLYPH_WIDTH_RST  = 6'd8;
	localparam logic        NARROW_SPACE_RST = 1'b1;
	localparam logic [31:0] BASE_COLOR_RST   = 32'hFFFF_FFFF;

	localparam logic [15:0] LINE_ADVANCE = 16'd8;
	localparam logic [15:0] SPACE_NARROW = 16'd7;
	localparam logic [15:0] SPACE_WIDE   = 16'd8;
	localparam logic [31:0] COLOR_WHITE  = 32'hFFFF_FFFF;
	localparam logic [31:0] COLOR_ZERO   = 32'h0000_0000;

	// escape codes
	localparam logic [1:0] ESC_NONE    = 2'd0;
	localparam logic [1:0] ESC_LETTER  = 2'd1;
	localparam logic [1:0] ESC_DISCARD = 2'd2;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_Y     = 8'h59;

	// glyph queue
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [5:0]  glyph_width;
		logic        narrow_space;
		logic [31:0] base_color;
	} cfg_t;

	// register write events that also load live state
	typedef struct packed {
		logic        ld_x;
		logic        ld_y;
		logic        ld_color;
		logic [31:0] data;
	} cfg_wr_t;

	// all glyphs of one character share row and color
	typedef struct packed {
		logic [1:0]       n;
		logic [15:0]      y;
		logic [31:0]      color;
		logic [2:0][15:0] x;
		logic [2:0][7:0]  code;
	} bundle_t;

	function automatic logic [31:0] letter_color(input logic [7:0] c);
		logic [31:0] r;
		case (c)
			CH_R:    r = 32'hFF00_00FF;
			CH_G:    r = 32'h00FF_00FF;
			CH_B:    r = 32'h0000_FFFF;
			CH_Y:    r = 32'hFFFF_00FF;
			CH_C:    r = 32'h00FF_FFFF;
			CH_M:    r = 32'hFF00_FFFF;
			default: r = COLOR_WHITE;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/tgl_regs.sv]
// ---------------------------------------------------------------------------
// tgl_regs: configuration register file
// APB-style write and read of the five layout registers.
// ---------------------------------------------------------------------------
module tgl_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tgl_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output tgl_pkg::cfg_t                cfg,
	output tgl_pkg::cfg_wr_t             cfg_wr
);

	tgl_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];

	// register storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x     <= tgl_pkg::ORIGIN_X_RST;
			cfg_q.origin_y     <= tgl_pkg::ORIGIN_Y_RST;
			cfg_q.glyph_width  <= tgl_pkg::GLYPH_WIDTH_RST;
			cfg_q.narrow_space <= tgl_pkg::NARROW_SPACE_RST;
			cfg_q.base_color   <= tgl_pkg::BASE_COLOR_RST;
		end else if (wr_en) begin
			case (idx)
				tgl_pkg::REG_ORIGIN_X:     cfg_q.origin_x     <= pwdata[15:0];
				tgl_pkg::REG_ORIGIN_Y:     cfg_q.origin_y     <= pwdata[15:0];
				tgl_pkg::REG_GLYPH_WIDTH:  cfg_q.glyph_width  <= pwdata[5:0];
				tgl_pkg::REG_NARROW_SPACE: cfg_q.narrow_space <= pwdata[0];
				tgl_pkg::REG_BASE_COLOR:   cfg_q.base_color   <= pwdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// load events for the live cursor and color
	assign cfg_wr.ld_x     = wr_en && (idx == tgl_pkg::REG_ORIGIN_X);
	assign cfg_wr.ld_y     = wr_en && (idx == tgl_pkg::REG_ORIGIN_Y);
	assign cfg_wr.ld_color = wr_en && (idx == tgl_pkg::REG_BASE_COLOR);
	assign cfg_wr.data     = pwdata;

	// read mux
	always_comb begin
		case (idx)
			tgl_pkg::REG_ORIGIN_X:     prdata = {16'd0, cfg_q.origin_x};
			tgl_pkg::REG_ORIGIN_Y:     prdata = {16'd0, cfg_q.origin_y};
			tgl_pkg::REG_GLYPH_WIDTH:  prdata = {26'd0, cfg_q.glyph_width};
			tgl_pkg::REG_NARROW_SPACE: prdata = {31'd0, cfg_q.narrow_space};
			tgl_pkg::REG_BASE_COLOR:   prdata = cfg_q.base_color;
			default:                   prdata = 32'd0;
		endcase
	end

endmodule

[rtl/core/tgl_front.sv]
// ---------------------------------------------------------------------------
// tgl_front: character classifier and cursor tracker
// Takes one character per cycle while the queue is not full, updates cursor,
// color, escape and dot state, and pushes a bundle of up to three glyphs into the queue.
// ---------------------------------------------------------------------------
module tgl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  tgl_pkg::cfg_t     cfg,
	input  tgl_pkg::cfg_wr_t  cfg_wr,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        char_code,
	input  logic              end_of_string,
	input  logic              q_full,
	output logic              q_push,
	output tgl_pkg::bundle_t  q_data
);

	logic [15:0] cx_q, cy_q;
	logic        hl_q;
	logic [31:0] col_q, sav_q;
	logic [1:0]  esc_q, dots_q;

	logic [15:0] cx, cy, fw16, half, quarter, ex;
	logic        hl;
	logic [31:0] col, sav;
	logic [1:0]  esc, dots, n;
	tgl_pkg::bundle_t b;
	logic        acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	assign fw16    = {10'd0, cfg.glyph_width};
	assign half    = fw16 >> 1;
	assign quarter = fw16 >> 2;

	// next state and glyph bundle for the offered character
	always_comb begin
		cx   = cx_q;
		cy   = cy_q;
		hl   = hl_q;
		col  = col_q;
		sav  = sav_q;
		esc  = esc_q;
		dots = dots_q;
		n    = 2'd0;
		ex   = cx_q - quarter;
		b    = '0;
		if (esc_q != tgl_pkg::ESC_NONE) begin
			// byte after '#': color letter or discarded
			if (esc_q == tgl_pkg::ESC_LETTER && col_q != tgl_pkg::COLOR_ZERO)
				col = tgl_pkg::letter_color(char_code);
			esc = tgl_pkg::ESC_NONE;
		end else if (char_code == tgl_pkg::CH_DOT) begin
			if (dots_q == 2'd2) begin
				// ellipsis: three wide dots
				b.x[0]    = ex;
				b.x[1]    = ex + fw16;
				b.x[2]    = ex + (fw16 << 1);
				b.code[0] = tgl_pkg::CH_DOT;
				b.code[1] = tgl_pkg::CH_DOT;
				b.code[2] = tgl_pkg::CH_DOT;
				n         = 2'd3;
				cx        = cx_q + (fw16 << 1) + fw16;
				dots      = 2'd0;
			end else begin
				dots = dots_q + 2'd1;
			end
		end else begin
			// flush pending dots as narrow glyphs
			for (int k = 0; k < 2; k++) begin
				if (2'(k) < dots_q) begin
					b.x[n]    = cx - half + 16'd1;
					b.code[n] = tgl_pkg::CH_DOT;
					n         = n + 2'd1;
					cx        = cx + 16'd2;
				end
			end
			dots = 2'd0;
			case (char_code)
				tgl_pkg::CH_NUL, tgl_pkg::CH_CR: ;
				tgl_pkg::CH_LF: begin
					cx = cfg.origin_x;
					cy = cy_q + tgl_pkg::LINE_ADVANCE;
				end
				tgl_pkg::CH_SPACE: begin
					cx = cx + (cfg.narrow_space ? tgl_pkg::SPACE_NARROW : tgl_pkg::SPACE_WIDE);
				end
				tgl_pkg::CH_TAB: begin
					cx = cx + (fw16 << 2) + fw16;
				end
				tgl_pkg::CH_HASH: begin
					hl = !hl_q;
					if (hl) begin
						sav = col_q;
						esc = tgl_pkg::ESC_LETTER;
					end else begin
						col = sav_q;
						esc = tgl_pkg::ESC_DISCARD;
					end
				end
				tgl_pkg::CH_COMMA, tgl_pkg::CH_SEMI, tgl_pkg::CH_APOS: begin
					b.x[n]    = cx - half + 16'd1;
					b.code[n] = char_code;
					n         = n + 2'd1;
					cx        = cx + 16'd2;
				end
				default: begin
					b.x[n]    = cx;
					b.code[n] = char_code;
					n         = n + 2'd1;
					cx        = cx + fw16;
				end
			endcase
		end
		if (end_of_string) begin
			// final flush, then rearm from the registers
			for (int k = 0; k < 2; k++) begin
				if (2'(k) < dots) begin
					b.x[n]    = cx - half + 16'd1;
					b.code[n] = tgl_pkg::CH_DOT;
					n         = n + 2'd1;
					cx        = cx + 16'd2;
				end
			end
			cx   = cfg.origin_x;
			cy   = cfg.origin_y;
			hl   = 1'b0;
			col  = cfg.base_color;
			sav  = tgl_pkg::COLOR_WHITE;
			esc  = tgl_pkg::ESC_NONE;
			dots = 2'd0;
		end
		// row and color never change ahead of a glyph within one character
		b.n     = n;
		b.y     = cy_q;
		b.color = col_q;
	end

	assign q_push = acc && (n != 2'd0);
	assign q_data = b;

	// layout state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q   <= tgl_pkg::ORIGIN_X_RST;
			cy_q   <= tgl_pkg::ORIGIN_Y_RST;
			hl_q   <= 1'b0;
			col_q  <= tgl_pkg::BASE_COLOR_RST;
			sav_q  <= tgl_pkg::COLOR_WHITE;
			esc_q  <= tgl_pkg::ESC_NONE;
			dots_q <= 2'd0;
		end else begin
			if (acc) begin
				cx_q   <= cx;
				cy_q   <= cy;
				hl_q   <= hl;
				col_q  <= col;
				sav_q  <= sav;
				esc_q  <= esc;
				dots_q <= dots;
			end
			if (cfg_wr.ld_x)
				cx_q <= cfg_wr.data[15:0];
			if (cfg_wr.ld_y)
				cy_q <= cfg_wr.data[15:0];
			if (cfg_wr.ld_color)
				col_q <= cfg_wr.data;
		end
	end

endmodule

[rtl/core/tgl_queue.sv]
// ---------------------------------------------------------------------------
// tgl_queue: glyph bundle queue
// Small FIFO between the front and back stages.
// ---------------------------------------------------------------------------
module tgl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tgl_pkg::bundle_t  push_data,
	output logic              full,
	input  logic              pop,
	output logic              q_valid,
	output tgl_pkg::bundle_t  head
);

	tgl_pkg::bundle_t         mem_q [tgl_pkg::QDEPTH];
	logic [tgl_pkg::QAW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [tgl_pkg::QAW:0]    cnt_q;
	logic                     do_pop;

	assign full    = (cnt_q == (tgl_pkg::QAW+1)'(tgl_pkg::QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign do_pop  = pop && q_valid;
	assign head    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/core/tgl_back.sv]
// ---------------------------------------------------------------------------
// tgl_back: glyph command emitter
// Walks the head bundle one glyph per cycle, unless out_ready stalls it, into the output register.
// ---------------------------------------------------------------------------
module tgl_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  tgl_pkg::bundle_t    head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  glyph_x,
	output logic signed [15:0]  glyph_y,
	output logic [7:0]          glyph_code,
	output logic [31:0]         glyph_color,
	output logic                last_of_run
);

	logic [1:0]  idx_q;
	logic        ov_q;
	logic        load, is_last;
	logic [15:0] x_s2, y_s2;
	logic [7:0]  code_s2;
	logic [31:0] color_s2;
	logic        last_s2;

	assign load    = q_valid && (!ov_q || out_ready);
	assign is_last = (idx_q == head.n - 2'd1);
	assign pop     = load && is_last;

	// output handshake and glyph index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			ov_q  <= 1'b0;
		end else begin
			if (load)
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			if (load)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			x_s2     <= head.x[idx_q];
			y_s2     <= head.y;
			code_s2  <= head.code[idx_q];
			color_s2 <= head.color;
			last_s2  <= is_last;
		end
	end

	assign out_valid   = ov_q;
	assign glyph_x     = x_s2;
	assign glyph_y     = y_s2;
	assign glyph_code  = code_s2;
	assign glyph_color = color_s2;
	assign last_of_run = last_s2;

endmodule

[rtl/core/text_glyph_layout_top.sv]
// ---------------------------------------------------------------------------
// text_glyph_layout_top: text glyph layout engine
// Path: an accepted request goes to the queue, then to the output register.
// Throughput: one character per cycle while the queue is not full; the output
// register delivers one glyph a cycle unless out_ready stalls it, so an
// ellipsis or a flush of dots holds the output until all its dots are out.
// A 4-entry bundle queue lets input keep flowing while output stalls.
// Reset: asynchronous, active low; ready at once, no clearing pass.
// ---------------------------------------------------------------------------
module text_glyph_layout_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tgl_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   char_code,
	input  logic                         end_of_string,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [15:0]           glyph_x,
	output logic signed [15:0]           glyph_y,
	output logic [7:0]                   glyph_code,
	output logic [31:0]                  glyph_color,
	output logic                         last_of_run
);

	tgl_pkg::cfg_t     cfg;
	tgl_pkg::cfg_wr_t  cfg_wr;
	tgl_pkg::bundle_t  push_data, head;
	logic              q_full, q_push, q_pop, q_valid;

	tgl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.cfg_wr  (cfg_wr)
	);

	tgl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cfg_wr        (cfg_wr),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.char_code     (char_code),
		.end_of_string (end_of_string),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (push_data)
	);

	tgl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.q_valid   (q_valid),
		.head      (head)
	);

	tgl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.head        (head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.glyph_x     (glyph_x),
		.glyph_y     (glyph_y),
		.glyph_code  (glyph_code),
		.glyph_color (glyph_color),
		.last_of_run (last_of_run)
	);

endmodule

[rtl/core/tgl_checker.sv]
// ---------------------------------------------------------------------------
// tgl_checker: port-level checks for the text glyph layout block
// Output handshake rules and properties of the emitted glyph codes.
// ---------------------------------------------------------------------------
module tgl_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         out_valid,
	input logic         out_ready,
	input logic [15:0]  glyph_x,
	input logic [7:0]   glyph_code,
	input logic         last_of_run
);

	// a stalled glyph stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("glyph request dropped while stalled");

	// a stalled glyph keeps its payload
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(glyph_x) && $stable(glyph_code))
		else $error("glyph payload changed while stalled");

	// control and spacing characters never draw
	a_no_ctrl_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> glyph_code != tgl_pkg::CH_NUL && glyph_code != tgl_pkg::CH_LF &&
		glyph_code != tgl_pkg::CH_CR && glyph_code != tgl_pkg::CH_SPACE &&
		glyph_code != tgl_pkg::CH_TAB && glyph_code != tgl_pkg::CH_HASH)
		else $error("control character emitted as glyph");

	// narrow punctuation other than dots always ends its run
	a_punct_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (glyph_code == tgl_pkg::CH_COMMA || glyph_code == tgl_pkg::CH_SEMI ||
		glyph_code == tgl_pkg::CH_APOS) |-> last_of_run)
		else $error("punctuation glyph not last of run");

endmodule

bind text_glyph_layout_top tgl_checker u_tgl_checker (.*);
